### sv/tpfl_pkg.sv
`timescale 1ns / 1ps

package tpfl_pkg;

    // field widths
    localparam int IDX_W      = 10;
    localparam int OP_W       = 3;
    localparam int STAT_W     = 2;
    localparam int REG_W      = 11;
    localparam int DSZ_W      = 12;
    localparam int ADDR_W     = 64;
    localparam int PROD_W     = IDX_W + DSZ_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // register reset values
    localparam logic [REG_W-1:0]  CAPACITY_RST  = REG_W'(1024);
    localparam logic [REG_W-1:0]  RSV_COUNT_RST = '0;
    localparam logic [DSZ_W-1:0]  DESC_SIZE_RST = DSZ_W'(32);
    localparam logic [ADDR_W-1:0] HEAP_BASE_RST = '0;

    // request operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ALLOC     = 3'd0,
        OP_ALLOC_RSV = 3'd1,
        OP_FREE      = 3'd2,
        OP_FREE_RSV  = 3'd3,
        OP_LOOKUP    = 3'd4,
        OP_RESTART   = 3'd5
    } t_op;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK          = 2'd0,
        ST_EMPTY       = 2'd1,
        ST_RSV_IGNORED = 2'd2,
        ST_GEN_FULL    = 2'd3
    } t_status;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAPACITY  = 2'd0,
        REG_RSV_COUNT = 2'd1,
        REG_DESC_SIZE = 2'd2,
        REG_HEAP_BASE = 2'd3
    } t_reg;

    // commands from the controller to the datapath
    typedef struct packed {
        logic latch;
        logic exec;
        logic mul;
        logic fin;
    } t_cmd;

endpackage

### sv/tpfl_ring.sv
`timescale 1ns / 1ps

module tpfl_ring #(
    parameter int MAX_SLOTS = 1024,
    parameter int RST_BASE  = 0,
    parameter int RST_COUNT = 0,
    localparam int IW = $clog2(MAX_SLOTS),
    localparam int CW = $clog2(MAX_SLOTS + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_refill,
    input  logic [CW-1:0]              i_fill_base,
    input  logic [CW-1:0]              i_fill_count,
    input  logic                       i_pop,
    input  logic                       i_push,
    input  logic [tpfl_pkg::IDX_W-1:0] i_push_data,
    output logic [CW-1:0]              o_count,
    output logic [tpfl_pkg::IDX_W-1:0] o_front
);
    import tpfl_pkg::*;

    logic [IDX_W-1:0] r_mem [MAX_SLOTS];
    logic [IW-1:0]    r_head, n_head;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_lazy, n_lazy;
    logic [CW-1:0]    r_base, n_base;
    logic [IDX_W-1:0] r_rdata;
    logic [IDX_W-1:0] r_lazy_val;
    logic             r_lazy_hit;
    logic [CW:0]      tail_sum;
    logic [IW-1:0]    tail;
    logic [CW:0]      lazy_sum;

    // tail position, wrapped once
    assign tail_sum = (CW+1)'(r_head) + (CW+1)'(r_count);
    assign tail     = (tail_sum >= (CW+1)'(MAX_SLOTS))
                    ? IW'(tail_sum - (CW+1)'(MAX_SLOTS)) : IW'(tail_sum);

    // entries not yet overwritten since refill hold base plus position
    assign lazy_sum = (CW+1)'(r_base) + (CW+1)'(r_head);

    // pointer and count update
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_lazy  = r_lazy;
        n_base  = r_base;
        if (i_refill) begin
            n_head  = '0;
            n_count = i_fill_count;
            n_lazy  = i_fill_count;
            n_base  = i_fill_base;
        end else if (i_pop) begin
            n_head  = (r_head == IW'(MAX_SLOTS - 1)) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
            if (r_lazy != '0) begin
                n_lazy = r_lazy - 1'b1;
            end
        end else if (i_push) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= CW'(RST_COUNT);
            r_lazy  <= CW'(RST_COUNT);
            r_base  <= CW'(RST_BASE);
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_lazy  <= n_lazy;
            r_base  <= n_base;
        end
    end

    // ring storage, registered read at the head
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[tail] <= i_push_data;
        end
        r_rdata <= r_mem[r_head];
    end

    // remember whether the popped entry came from the refill sequence
    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            r_lazy_hit <= (r_lazy != '0);
            r_lazy_val <= IDX_W'(lazy_sum);
        end
    end

    assign o_count = r_count;
    assign o_front = r_lazy_hit ? r_lazy_val : r_rdata;

endmodule

### sv/tpfl_ctrl.sv
`timescale 1ns / 1ps

module tpfl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    output logic           o_done,
    output tpfl_pkg::t_cmd o_cmd
);
    import tpfl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_ADD
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_done;

    // sequencer: accept, update lists, multiply, add
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_EXEC;
                        r_busy  <= 1'b1;
                    end
                end
                S_EXEC: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                    r_done  <= 1'b1;
                end
            endcase
        end
    end

    // datapath commands
    assign o_cmd.latch = (r_state == S_IDLE) && i_start;
    assign o_cmd.exec  = (r_state == S_EXEC);
    assign o_cmd.mul   = (r_state == S_MUL);
    assign o_cmd.fin   = (r_state == S_ADD);

    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

### sv/tpfl_dp.sv
`timescale 1ns / 1ps

module tpfl_dp #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tpfl_pkg::t_cmd                  i_cmd,
    input  logic [tpfl_pkg::OP_W-1:0]       i_operation,
    input  logic [tpfl_pkg::IDX_W-1:0]      i_slot_index,
    input  logic                            i_cfg_we,
    input  logic [tpfl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tpfl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic [tpfl_pkg::IDX_W-1:0]      o_result_index,
    output logic [tpfl_pkg::STAT_W-1:0]     o_status,
    output logic [tpfl_pkg::ADDR_W-1:0]     o_handle_address
);
    import tpfl_pkg::*;

    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int LW = (CW > REG_W) ? CW : REG_W;
    localparam int GEN_RST_COUNT = (MAX_SLOTS < 1024) ? MAX_SLOTS : 1024;

    typedef enum logic [1:0] {
        SRC_SLOT,
        SRC_GEN,
        SRC_RSV
    } t_src;

    // configuration registers
    logic [REG_W-1:0]  r_capacity;
    logic [REG_W-1:0]  r_rsv_count;
    logic [DSZ_W-1:0]  r_desc_size;
    logic [ADDR_W-1:0] r_heap_base;

    // request and working registers
    t_op               r_op;
    logic [IDX_W-1:0]  r_slot;
    logic [IDX_W-1:0]  r_idx_pre, n_idx_pre;
    t_status           r_status, n_status;
    t_src              r_src, n_src;
    logic [IDX_W-1:0]  r_idx;
    logic [PROD_W-1:0] r_prod;
    logic [IDX_W-1:0]  r_res_idx;
    t_status           r_res_status;
    logic [ADDR_W-1:0] r_res_addr;

    // list control
    logic             gen_pop, gen_push, rsv_pop, rsv_push, refill;
    logic [CW-1:0]    gen_count, rsv_count;
    logic [IDX_W-1:0] gen_front, rsv_front;
    logic [LW-1:0]    cap_c, rc_c, gen_n;
    logic [IDX_W-1:0] idx_sel;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAPACITY_RST;
            r_rsv_count <= RSV_COUNT_RST;
            r_desc_size <= DESC_SIZE_RST;
            r_heap_base <= HEAP_BASE_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_index))
                REG_CAPACITY:  r_capacity  <= i_cfg_data[REG_W-1:0];
                REG_RSV_COUNT: r_rsv_count <= i_cfg_data[REG_W-1:0];
                REG_DESC_SIZE: r_desc_size <= i_cfg_data[DSZ_W-1:0];
                REG_HEAP_BASE: r_heap_base <= i_cfg_data;
            endcase
        end
    end

    // refill sizes, clamped to the ring depth
    assign cap_c = (LW'(r_capacity) > LW'(MAX_SLOTS)) ? LW'(MAX_SLOTS) : LW'(r_capacity);
    assign rc_c  = (LW'(r_rsv_count) > LW'(MAX_SLOTS)) ? LW'(MAX_SLOTS) : LW'(r_rsv_count);
    assign gen_n = (cap_c > rc_c) ? cap_c - rc_c : '0;

    // operation decode and list commands
    always_comb begin
        gen_pop   = 1'b0;
        gen_push  = 1'b0;
        rsv_pop   = 1'b0;
        rsv_push  = 1'b0;
        refill    = 1'b0;
        n_idx_pre = '0;
        n_status  = ST_OK;
        n_src     = SRC_SLOT;
        if (i_cmd.exec) begin
            unique case (r_op)
                OP_ALLOC: begin
                    if (gen_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        gen_pop = 1'b1;
                        n_src   = SRC_GEN;
                    end
                end
                OP_ALLOC_RSV: begin
                    if (rsv_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        rsv_pop = 1'b1;
                        n_src   = SRC_RSV;
                    end
                end
                OP_FREE: begin
                    n_idx_pre = r_slot;
                    if (gen_count == CW'(MAX_SLOTS)) begin
                        n_status = ST_GEN_FULL;
                    end else begin
                        gen_push = 1'b1;
                    end
                end
                OP_FREE_RSV: begin
                    n_idx_pre = r_slot;
                    if ({1'b0, r_slot} >= r_rsv_count || rsv_count == CW'(MAX_SLOTS)) begin
                        n_status = ST_RSV_IGNORED;
                    end else begin
                        rsv_push = 1'b1;
                    end
                end
                OP_LOOKUP: begin
                    n_idx_pre = r_slot;
                end
                OP_RESTART: begin
                    refill = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // general pool ring
    tpfl_ring #(
        .MAX_SLOTS (MAX_SLOTS),
        .RST_BASE  (0),
        .RST_COUNT (GEN_RST_COUNT)
    ) u_gen_ring (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_refill     (refill),
        .i_fill_base  (CW'(rc_c)),
        .i_fill_count (CW'(gen_n)),
        .i_pop        (gen_pop),
        .i_push       (gen_push),
        .i_push_data  (r_slot),
        .o_count      (gen_count),
        .o_front      (gen_front)
    );

    // reserved pool ring
    tpfl_ring #(
        .MAX_SLOTS (MAX_SLOTS),
        .RST_BASE  (0),
        .RST_COUNT (0)
    ) u_rsv_ring (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_refill     (refill),
        .i_fill_base  ('0),
        .i_fill_count (CW'(rc_c)),
        .i_pop        (rsv_pop),
        .i_push       (rsv_push),
        .i_push_data  (r_slot),
        .o_count      (rsv_count),
        .o_front      (rsv_front)
    );

    // request capture and decode results
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= t_op'(i_operation);
            r_slot <= i_slot_index;
        end
        if (i_cmd.exec) begin
            r_idx_pre <= n_idx_pre;
            r_status  <= n_status;
            r_src     <= n_src;
        end
    end

    // index selection: popped entry or request index
    always_comb begin
        unique case (r_src)
            SRC_GEN: idx_sel = gen_front;
            SRC_RSV: idx_sel = rsv_front;
            default: idx_sel = r_idx_pre;
        endcase
    end

    // handle address: multiply, then add base
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_idx  <= idx_sel;
            r_prod <= PROD_W'(idx_sel) * PROD_W'(r_desc_size);
        end
        if (i_cmd.fin) begin
            r_res_idx    <= r_idx;
            r_res_status <= r_status;
            r_res_addr   <= r_heap_base + ADDR_W'(r_prod);
        end
    end

    assign o_result_index   = r_res_idx;
    assign o_status         = r_res_status;
    assign o_handle_address = r_res_addr;

endmodule

### sv/two_pool_index_free_list_top.sv
`timescale 1ns / 1ps
// channel    | direction | ports                                          | handshake
// request    | in        | i_operation, i_slot_index                      | start, busy
// result     | out       | o_result_index, o_status, o_handle_address     | o_done
// config     | in        | i_cfg_index, i_cfg_data                        | i_cfg_we
//
// a request is taken when start is high and busy is low; busy then stays high
// through the list update, index multiply and base add states, and o_done marks
// the result for one cycle; a new request is not taken until busy falls.
// reset is synchronous; afterwards the general list is full and the reserved
// list empty at once (lazy refill, no clearing pass); restart refills the same way.
// results cannot be held off by the receiver.

module two_pool_index_free_list_top #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [tpfl_pkg::OP_W-1:0]       i_operation,
    input  logic [tpfl_pkg::IDX_W-1:0]      i_slot_index,
    output logic                            o_done,
    output logic [tpfl_pkg::IDX_W-1:0]      o_result_index,
    output logic [tpfl_pkg::STAT_W-1:0]     o_status,
    output logic [tpfl_pkg::ADDR_W-1:0]     o_handle_address,
    input  logic                            i_cfg_we,
    input  logic [tpfl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tpfl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tpfl_pkg::*;

    t_cmd cmd;

    // sequencer
    tpfl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    // lists, registers and address arithmetic
    tpfl_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_operation      (i_operation),
        .i_slot_index     (i_slot_index),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_result_index   (o_result_index),
        .o_status         (o_status),
        .o_handle_address (o_handle_address)
    );

endmodule
